// ===== hdl/rer_pkg.sv =====
package rer_pkg;

  localparam int MAX_HALF      = 128;
  localparam int MAX_POSITIONS = 64;
  localparam int FRAC_BITS     = 14;
  localparam int TABLE_DEPTH   = MAX_POSITIONS * MAX_HALF;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int HALF_W        = 8;
  localparam int POS_W         = 6;
  localparam int IDX_W         = 7;
  localparam int DATA_W        = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HALF_W-1:0] HALF_DIM_RESET = HALF_W'(MAX_HALF);

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_ROTATE = 1'b1
  } mode_t;

  // classified item as it travels from front to back
  typedef struct packed {
    mode_t                     mode;
    logic                      ok;
    logic [ADDR_W-1:0]         addr;
    logic signed [DATA_W-1:0]  first;
    logic signed [DATA_W-1:0]  second;
  } entry_t;

endpackage

// ===== hdl/rer_if.sv =====
interface rer_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         position;
  logic [6:0]         element_index;
  logic signed [15:0] first_value;
  logic signed [15:0] second_value;

  modport source (output valid, mode, position, element_index, first_value, second_value,
                  input ready);
  modport sink   (input valid, mode, position, element_index, first_value, second_value,
                  output ready);
endinterface

interface rer_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rotated_first;
  logic signed [15:0] rotated_second;
  logic               saturated;
  logic               index_error;

  modport source (output valid, rotated_first, rotated_second, saturated, index_error,
                  input ready);
  modport sink   (input valid, rotated_first, rotated_second, saturated, index_error,
                  output ready);
endinterface

// ===== hdl/rer_front.sv =====
module rer_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [rer_pkg::HALF_W-1:0]  cfg_write_data,
  rer_in_if.sink                      item,
  input  logic                        queue_space,
  output logic                        push,
  output rer_pkg::entry_t             push_entry
);
  import rer_pkg::*;

  logic [HALF_W-1:0]       half_dim;
  logic [POS_W+HALF_W-1:0] row_base;
  logic [POS_W+HALF_W-1:0] addr_full;
  logic                    ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_dim <= HALF_DIM_RESET;
    end else if (cfg_write_enable) begin
      half_dim <= cfg_write_data;
    end
  end

  always_comb begin
    row_base  = (POS_W+HALF_W)'(item.position) * (POS_W+HALF_W)'(half_dim);
    addr_full = row_base + (POS_W+HALF_W)'(item.element_index);
    // position is always below the row count at these widths
    ok = (half_dim != '0) && ({1'b0, half_dim} <= (HALF_W+1)'(MAX_HALF)) &&
         ((HALF_W)'(item.element_index) < half_dim) &&
         (addr_full < (POS_W+HALF_W)'(TABLE_DEPTH));
  end

  assign item.ready = queue_space;
  assign push       = item.valid && queue_space;

  always_comb begin
    push_entry.mode   = mode_t'(item.mode);
    push_entry.ok     = ok;
    push_entry.addr   = addr_full[ADDR_W-1:0];
    push_entry.first  = item.first_value;
    push_entry.second = item.second_value;
  end

endmodule

// ===== hdl/rer_queue.sv =====
module rer_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rer_pkg::entry_t  push_entry,
  output logic             space,
  output logic             head_valid,
  output rer_pkg::entry_t  head_entry,
  input  logic             pop
);
  import rer_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign space      = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/rer_back.sv =====
module rer_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  rer_pkg::entry_t  head_entry,
  output logic             pop,
  rer_out_if.source        result
);
  import rer_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QW     = SUM_W - FRAC_BITS;

  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic              sat;
  } rounded_t;

  logic [2*DATA_W-1:0] table_mem [TABLE_DEPTH];

  logic                     advance;
  logic                     rotate_pop;

  // stage 1: table read
  logic                     s1_valid;
  logic                     s1_err;
  logic [2*DATA_W-1:0]      s1_coef;
  logic signed [DATA_W-1:0] s1_x1;
  logic signed [DATA_W-1:0] s1_x2;

  // stage 2: products
  logic                     s2_valid;
  logic                     s2_err;
  logic signed [PROD_W-1:0] s2_x1c;
  logic signed [PROD_W-1:0] s2_x2s;
  logic signed [PROD_W-1:0] s2_x2c;
  logic signed [PROD_W-1:0] s2_x1s;

  logic signed [DATA_W-1:0] s1_cos;
  logic signed [DATA_W-1:0] s1_sin;
  logic signed [SUM_W-1:0]  sum_first;
  logic signed [SUM_W-1:0]  sum_second;
  rounded_t                 rnd_first;
  rounded_t                 rnd_second;

  function automatic rounded_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [QW-1:0]  q;
    logic [FRAC_BITS-1:0]  rem;
    logic                  up;
    logic signed [QW:0]    r;
    rounded_t              res;
    q   = v[SUM_W-1:FRAC_BITS];
    rem = v[FRAC_BITS-1:0];
    up  = (rem > FRAC_BITS'(1 << (FRAC_BITS - 1))) ||
          ((rem == FRAC_BITS'(1 << (FRAC_BITS - 1))) && q[0]);
    r   = {q[QW-1], q} + (QW+1)'(up);
    if (r > (QW+1)'(signed'(32'sd32767))) begin
      res.q   = DATA_W'(16'h7FFF);
      res.sat = 1'b1;
    end else if (r < (QW+1)'(-32'sd32768)) begin
      res.q   = DATA_W'(16'h8000);
      res.sat = 1'b1;
    end else begin
      res.q   = r[DATA_W-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  assign advance    = !result.valid || result.ready;
  assign pop        = advance && head_valid;
  assign rotate_pop = pop && (head_entry.mode == MODE_ROTATE);

  always_ff @(posedge clk) begin
    if (pop && (head_entry.mode == MODE_LOAD) && head_entry.ok) begin
      table_mem[head_entry.addr] <= {head_entry.second, head_entry.first};
    end
    if (advance) begin
      s1_coef <= table_mem[head_entry.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err <= !head_entry.ok;
      s1_x1  <= head_entry.first;
      s1_x2  <= head_entry.second;
    end
  end

  assign s1_cos = s1_coef[DATA_W-1:0];
  assign s1_sin = s1_coef[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_err <= s1_err;
      s2_x1c <= s1_x1 * s1_cos;
      s2_x2s <= s1_x2 * s1_sin;
      s2_x2c <= s1_x2 * s1_cos;
      s2_x1s <= s1_x1 * s1_sin;
    end
  end

  always_comb begin
    sum_first  = SUM_W'(s2_x1c) - SUM_W'(s2_x2s);
    sum_second = SUM_W'(s2_x2c) + SUM_W'(s2_x1s);
    rnd_first  = round_sat(sum_first);
    rnd_second = round_sat(sum_second);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s2_err) begin
        result.rotated_first  <= '0;
        result.rotated_second <= '0;
        result.saturated      <= 1'b0;
      end else begin
        result.rotated_first  <= rnd_first.q;
        result.rotated_second <= rnd_second.q;
        result.saturated      <= rnd_first.sat || rnd_second.sat;
      end
      result.index_error <= s2_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= rotate_pop;
      s2_valid     <= s1_valid;
      result.valid <= s2_valid;
    end
  end

endmodule

// ===== hdl/rotary_embedding_rotator.sv =====
// channel   dir  transaction                                      payload
// item      in   load (mode 0) or rotate (mode 1) request         mode, position, index, x1/x2
// result    out  one per rotate request, in request order         y1, y2, saturated, index_error
// cfg       in   write of half_dim, no handshake                  8-bit data
//
// A request is classified and queued in the cycle it is taken; up to four wait in the queue.
// The back end takes one queued transaction per cycle while the result side is not stalled: a load
// writes the table, a rotate passes through registered table read, multiply and round/saturate stages.
// Sustained rate is one request per cycle while the result side keeps taking.
// A stall on the result side freezes the back pipeline; the queue keeps taking until full.
// Synchronous reset empties queue and pipeline and sets half_dim to 128; the table is not reset.
module rotary_embedding_rotator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [rer_pkg::HALF_W-1:0]  cfg_write_data,
  rer_in_if.sink                      item,
  rer_out_if.source                   result
);
  import rer_pkg::*;

  logic   queue_space;
  logic   push;
  entry_t push_entry;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  rer_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .item             (item),
    .queue_space      (queue_space),
    .push             (push),
    .push_entry       (push_entry)
  );

  rer_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .space      (queue_space),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  rer_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== hdl/rer_checker.sv =====
module rer_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [15:0] rotated_first,
  input logic signed [15:0] rotated_second,
  input logic               saturated,
  input logic               index_error
);

  // a rejected rotate carries nothing but its flag
  assert property (@(posedge clk) disable iff (rst)
    result_valid && index_error |-> rotated_first == 16'sd0 && rotated_second == 16'sd0 &&
                                    !saturated)
    else $error("index_error result with nonzero payload");

  // a clipped result must sit on a rail
  assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      rotated_first == 16'sh7FFF || rotated_first == 16'sh8000 ||
      rotated_second == 16'sh7FFF || rotated_second == 16'sh8000)
    else $error("saturated set but no result at a rail");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(rotated_first) &&
      $stable(rotated_second) && $stable(saturated) && $stable(index_error))
    else $error("stalled result changed");

endmodule

bind rotary_embedding_rotator rer_checker u_rer_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .rotated_first  (result.rotated_first),
  .rotated_second (result.rotated_second),
  .saturated      (result.saturated),
  .index_error    (result.index_error)
);

// ===== tb/testbench.sv =====
module testbench;
  import rer_pkg::*;

  localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 12;    // long enough to drain queue and pipeline, with margin
  localparam int VALID_COUNT   = 170;
  localparam int INVALID_COUNT = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
    logic                     sat;
    logic                     ierr;
  } rot_result_t;

  class rotation_checker;
    logic [31:0]       cos_sin [TABLE_DEPTH];
    bit                loaded  [TABLE_DEPTH];
    logic [HALF_W-1:0] half_dim = HALF_DIM_RESET;
    rot_result_t       pending_rotations [$];
    int                mismatches = 0;

    function int pending();
      return pending_rotations.size();
    endfunction

    function int entry_addr(logic [POS_W-1:0] pos, logic [IDX_W-1:0] idx);
      return int'(pos) * int'(half_dim) + int'(idx);
    endfunction

    function bit is_loaded(logic [POS_W-1:0] pos, logic [IDX_W-1:0] idx);
      return loaded[entry_addr(pos, idx)];
    endfunction

    // arithmetic shift by FRAC_BITS, round half to even, clip to 16 bits
    function logic signed [DATA_W-1:0] shift_round_sat(longint acc, inout logic sat);
      longint q;
      longint rem;
      longint half;
      half = longint'(1) << (FRAC_BITS - 1);
      q    = acc >>> FRAC_BITS;
      rem  = acc & ((longint'(1) << FRAC_BITS) - 1);
      if (rem > half || (rem == half && q[0]))
        q++;
      if (q > 32767) begin
        q   = 32767;
        sat = 1'b1;
      end else if (q < -32768) begin
        q   = -32768;
        sat = 1'b1;
      end
      return q[DATA_W-1:0];
    endfunction

    function void note_item(mode_t mode, logic [POS_W-1:0] pos, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      bit          ok;
      int          addr;
      rot_result_t r;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] s;
      ok   = half_dim >= 1 && half_dim <= MAX_HALF && idx < half_dim &&
             pos < MAX_POSITIONS;
      addr = entry_addr(pos, idx);
      if (ok && addr >= TABLE_DEPTH)
        ok = 0;
      if (mode == MODE_LOAD) begin
        if (ok) begin
          cos_sin[addr] = {b, a};
          loaded[addr]  = 1;
        end
        return;
      end
      r = '0;
      if (!ok) begin
        r.ierr = 1'b1;
      end else begin
        c = cos_sin[addr][15:0];
        s = cos_sin[addr][31:16];
        r.sat    = 1'b0;
        r.first  = shift_round_sat(longint'(a) * c - longint'(b) * s, r.sat);
        r.second = shift_round_sat(longint'(b) * c + longint'(a) * s, r.sat);
      end
      pending_rotations.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] y1, logic signed [DATA_W-1:0] y2,
                               logic sat, logic ierr);
      rot_result_t got;
      rot_result_t want;
      got.first  = y1;
      got.second = y2;
      got.sat    = sat;
      got.ierr   = ierr;
      if (pending_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: y1=%0d y2=%0d sat=%b ierr=%b", y1, y2, sat, ierr);
        return;
      end
      want = pending_rotations.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected y1=%0d y2=%0d sat=%b ierr=%b, got y1=%0d y2=%0d sat=%b ierr=%b",
                   want.first, want.second, want.sat, want.ierr, y1, y2, sat, ierr);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write_enable;
  logic [HALF_W-1:0] cfg_write_data;

  rer_in_if  item_ch ();
  rer_out_if result_ch ();

  rotary_embedding_rotator u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .item             (item_ch),
    .result           (result_ch)
  );

  rotation_checker sb = new();
  int              items_taken = 0;
  bit              tx_steady = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] table_value();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      return DATA_W'(int'($urandom_range(32768)) - 16384);
    else if (r < 80)
      return DATA_W'($urandom_range(65535));
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] sample_value();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      return DATA_W'($urandom_range(65535));
    else if (r < 80)
      return DATA_W'(int'($urandom_range(200)) - 100);
    case ($urandom_range(3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic offer(input mode_t m, input logic [POS_W-1:0] p, input logic [IDX_W-1:0] ix,
                       input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.mode          <= m;
    item_ch.position      <= p;
    item_ch.element_index <= ix;
    item_ch.first_value   <= a;
    item_ch.second_value  <= b;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(m, p, ix, a, b);
    items_taken++;
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // trailing loads give no result, let them drain too
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_dim(input logic [HALF_W-1:0] v);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    sb.half_dim = v;
  endtask

  task automatic random_items(input int count);
    int                n;
    int                r;
    int                hd;
    bit                hd_ok;
    logic [POS_W-1:0]  p;
    logic [IDX_W-1:0]  ix;
    logic [12:0]       pick;
    logic [12:0]       recent [$];
    mode_t             m;
    hd    = int'(sb.half_dim);
    hd_ok = hd >= 1 && hd <= MAX_HALF;
    n     = 0;
    while (n < count) begin
      r = $urandom_range(99);
      p = POS_W'($urandom_range(MAX_POSITIONS - 1));
      if (!hd_ok) begin
        // every access is out of range here: rotates flag, loads are dropped
        m = mode_t'($urandom_range(1));
        offer(m, p, IDX_W'($urandom_range(127)), DATA_W'($urandom_range(65535)),
              DATA_W'($urandom_range(65535)));
        if (m == MODE_ROTATE)
          n++;
      end else if (r < 30 || (r >= 80 && hd == MAX_HALF)) begin
        ix = IDX_W'($urandom_range(hd - 1));
        offer(MODE_LOAD, p, ix, table_value(), table_value());
        recent.push_back({p, ix});
        if (recent.size() > 64)
          void'(recent.pop_front());
        n++;
      end else if (r < 80) begin
        ix = IDX_W'($urandom_range(hd - 1));
        if (!sb.is_loaded(p, ix) && recent.size() > 0) begin
          pick = recent[$urandom_range(recent.size() - 1)];
          p    = pick[12:7];
          ix   = pick[6:0];
        end
        if (sb.is_loaded(p, ix))
          offer(MODE_ROTATE, p, ix, sample_value(), sample_value());
        else
          offer(MODE_LOAD, p, ix, table_value(), table_value());
        n++;
      end else if (r < 90) begin
        offer(MODE_ROTATE, p, IDX_W'($urandom_range(hd, 127)), sample_value(),
              sample_value());
        n++;
      end else begin
        offer(MODE_LOAD, p, IDX_W'($urandom_range(hd, 127)), table_value(), table_value());
      end
    end
  endtask

  task automatic run_phase(input logic [HALF_W-1:0] hd);
    settle();
    write_half_dim(hd);
    tx_steady = ($urandom_range(3) == 0);
    random_items((hd >= 1 && hd <= MAX_HALF) ? VALID_COUNT : INVALID_COUNT);
  endtask

  // result side: random back-pressure plus one long hold-off to fill the block
  initial begin
    int hold;
    int span;
    bit calm;
    bit pressed;
    hold = 0;
    span = 0;
    calm = 0;
    pressed = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.rotated_first, result_ch.rotated_second,
                        result_ch.saturated, result_ch.index_error);
      if (span == 0) begin
        calm = ($urandom_range(3) == 0);
        span = $urandom_range(50, 300);
      end else begin
        span--;
      end
      if (!pressed && items_taken >= 300) begin
        pressed = 1;
        hold    = 120;
      end
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if (calm || $urandom_range(99) < 65) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        hold = idle_len();
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [HALF_W-1:0] plan [8];
    plan = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd64, 8'd129, 8'd37, 8'd2};
    rst                   <= 1'b1;
    cfg_write_enable      <= 1'b0;
    cfg_write_data        <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.mode          <= 1'b0;
    item_ch.position      <= '0;
    item_ch.element_index <= '0;
    item_ch.first_value   <= '0;
    item_ch.second_value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset stride 128: corner entries, exact unity, rounding ties, clipping
    offer(MODE_LOAD,   6'd0,  7'd0,   16'sd16384,  16'sd0);
    offer(MODE_ROTATE, 6'd0,  7'd0,   16'sd32767,  -16'sd32768);
    offer(MODE_LOAD,   6'd63, 7'd127, -16'sd32768, -16'sd32768);
    offer(MODE_ROTATE, 6'd63, 7'd127, -16'sd32768, -16'sd32768);
    offer(MODE_LOAD,   6'd1,  7'd5,   16'sd1,      16'sd0);
    offer(MODE_ROTATE, 6'd1,  7'd5,   16'sd8192,   16'sd24576);   // ties to even
    offer(MODE_ROTATE, 6'd1,  7'd5,   -16'sd8192,  -16'sd24576);
    offer(MODE_ROTATE, 6'd1,  7'd5,   16'sd8193,   -16'sd8193);
    offer(MODE_LOAD,   6'd2,  7'd64,  16'sd11585,  16'sd11585);
    offer(MODE_ROTATE, 6'd2,  7'd64,  16'sd32767,  16'sd32767);
    offer(MODE_LOAD,   6'd3,  7'd3,   16'sd0,      16'sd16384);
    offer(MODE_ROTATE, 6'd3,  7'd3,   -16'sd32768, -16'sd32768);
    offer(MODE_LOAD,   6'd0,  7'd0,   16'sh1234,   -16'sd4660);   // overwrite
    offer(MODE_ROTATE, 6'd0,  7'd0,   16'sd32767,  16'sd32767);
    offer(MODE_LOAD,   6'd63, 7'd0,   16'sd16383,  -16'sd1);
    offer(MODE_ROTATE, 6'd63, 7'd0,   16'sd0,      16'sd0);
    random_items(VALID_COUNT);

    // stride 1: only index 0 is in range
    settle();
    write_half_dim(8'd1);
    offer(MODE_LOAD,   6'd5,  7'd0,   16'sd16384,  16'sd16384);
    offer(MODE_ROTATE, 6'd5,  7'd0,   16'sd20000,  -16'sd20000);
    offer(MODE_ROTATE, 6'd5,  7'd1,   16'sd100,    16'sd100);
    offer(MODE_LOAD,   6'd5,  7'd127, 16'sd1,      16'sd1);       // dropped
    offer(MODE_ROTATE, 6'd63, 7'd127, 16'sd1,      16'sd1);
    random_items(VALID_COUNT);

    for (int i = 1; i < 8; i++)
      run_phase(plan[i]);
    run_phase(HALF_W'($urandom_range(1, MAX_HALF)));

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
